// File: rtl/core/smx_pkg.sv
package smx_pkg;

   localparam int MAX_LEN_DFLT = 64;
   localparam int FRAC_BITS    = 50;
   localparam int SERIES_TERMS = 24;
   localparam int TERM_DIV_STEPS = 13;  // 52-bit term, 4 quotient bits per step
   localparam int OUT_DIV_STEPS  = 17;  // quotient bits of e * 2^16 / sum

   typedef struct packed {
      logic signed [15:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [15:0] probability;
      logic [5:0]  position;
      logic        final_res;
      logic        overflowed;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_INIT_LOAD,
      OP_SER_MUL,
      OP_SER_DIV,
      OP_INIT_ADD,
      OP_EXP_LOAD,
      OP_EXP_ADD,
      OP_DROP,
      OP_QM_CLEAR,
      OP_QM_PROD,
      OP_QM_ACC,
      OP_QM_DONE,
      OP_STORE,
      OP_RD,
      OP_ODIV_LOAD,
      OP_ODIV_STEP,
      OP_OUT_LOAD,
      OP_OUT_NEXT,
      OP_CLEAR
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [4:0] k;
      logic [1:0] pp;
      logic       first;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic mag_zero;
      logic last;
      logic idx_final;
   } dp_status_type;

   typedef enum logic [4:0] {
      S_INIT_START,
      S_INIT_MUL,
      S_INIT_DIV,
      S_INIT_ADD,
      S_IDLE,
      S_EXP_MUL,
      S_EXP_DIV,
      S_EXP_ADD,
      S_QM_START,
      S_QM_PROD,
      S_QM_ACC,
      S_QM_DONE,
      S_STORE,
      S_RD,
      S_ODIV_LOAD,
      S_ODIV,
      S_OUT_LOAD,
      S_OUT
   } smx_state_type;

endpackage

// File: rtl/core/softmax_vector_unit.sv
// Each accepted element runs the 24-term series, then 0 to 8 power-of-e
// multiplies, by the integer part. Each result then comes from the bit-serial
// 17-step division. One element at a time; the input stalls until its work is
// done, and after the last element until all its results are done.
// Reset is synchronous, active high; after it, the same series unit builds e and
// 1/e before the first element is taken.
module softmax_vector_unit #(
   parameter int MAX_LEN = smx_pkg::MAX_LEN_DFLT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  smx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output smx_pkg::rsp_type rsp_data
);
   import smx_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   smx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   smx_dp #(
      .MAX_LEN (MAX_LEN)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

// File: rtl/core/smx_dp.sv
module smx_dp #(
   parameter int MAX_LEN = smx_pkg::MAX_LEN_DFLT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  smx_pkg::req_type      req_data,
   input  smx_pkg::dp_cmd_type   cmd,
   output smx_pkg::dp_status_type status,
   output smx_pkg::rsp_type      rsp_data
);
   import smx_pkg::*;

   localparam int AddrWidth = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CntWidth  = $clog2(MAX_LEN + 1);

   logic [27:0] mem [MAX_LEN];

   logic [63:0] acc_ff, econst_ff, einv_ff, step;
   logic [51:0] term_ff, term_in;
   logic [4:0]  rem_ff, rem_in;
   logic [12:0] f_ff;
   logic        neg_ff;
   logic [3:0]  mag_ff;
   logic        last_ff;
   logic [63:0] prod_ff;
   logic [127:0] pacc_ff, pacc_add;
   logic [64:0] ser_prod;
   logic [31:0] a_sel, b_sel;
   logic [33:0] sum_ff;
   logic [CntWidth-1:0]  count_ff;
   logic [AddrWidth-1:0] idx_ff;
   logic        drop_ff;
   logic [27:0] rd_ff;
   logic [34:0] drem_ff, drem_in;
   logic [16:0] q_ff;
   logic        qbit;
   logic [15:0] u;
   logic        idx_final;
   rsp_type     out_ff;

   assign u         = {~req_data.value[15], req_data.value[14:0]};
   assign step      = neg_ff ? einv_ff : econst_ff;
   assign ser_prod  = 65'(term_ff) * 65'(f_ff);
   assign a_sel     = cmd.pp[1] ? acc_ff[63:32] : acc_ff[31:0];
   assign b_sel     = cmd.pp[0] ? step[63:32] : step[31:0];
   assign idx_final = (CntWidth'(idx_ff) + CntWidth'(1)) == count_ff;

   always_comb begin
      unique case (cmd.pp)
         2'd0:    pacc_add = {64'd0, prod_ff};
         2'd3:    pacc_add = {prod_ff, 64'd0};
         default: pacc_add = {32'd0, prod_ff, 32'd0};
      endcase
   end

   // radix-16 restoring division of the term by k
   always_comb begin
      logic [5:0]  r;
      logic [51:0] t;
      r = {1'b0, rem_ff};
      t = term_ff;
      for (int j = 0; j < 4; j++) begin
         r = {r[4:0], t[51]};
         t = {t[50:0], 1'b0};
         if (r >= {1'b0, cmd.k}) begin
            r = r - {1'b0, cmd.k};
            t[0] = 1'b1;
         end
      end
      term_in = t;
      rem_in  = r[4:0];
   end

   always_comb begin
      logic [34:0] r2;
      r2 = cmd.first ? drem_ff : {drem_ff[33:0], 1'b0};
      qbit = 1'b0;
      if (r2 >= {1'b0, sum_ff}) begin
         r2   = r2 - {1'b0, sum_ff};
         qbit = 1'b1;
      end
      drem_in = r2;
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_INIT_LOAD: begin
            term_ff   <= 52'(64'd1 << FRAC_BITS);
            econst_ff <= 64'd1 << FRAC_BITS;
            einv_ff   <= 64'd1 << FRAC_BITS;
            f_ff      <= 13'd4096;
         end
         OP_SER_MUL: begin
            term_ff <= ser_prod[63:12];
            rem_ff  <= '0;
         end
         OP_SER_DIV: begin
            term_ff <= term_in;
            rem_ff  <= rem_in;
         end
         OP_INIT_ADD: begin
            econst_ff <= econst_ff + 64'(term_ff);
            // odd terms alternate sign for 1/e
            if (cmd.k[0]) begin
               einv_ff <= einv_ff - 64'(term_ff);
            end else begin
               einv_ff <= einv_ff + 64'(term_ff);
            end
         end
         OP_EXP_LOAD: begin
            term_ff <= 52'(64'd1 << FRAC_BITS);
            acc_ff  <= 64'd1 << FRAC_BITS;
            f_ff    <= {1'b0, u[11:0]};
            neg_ff  <= ~u[15];
            mag_ff  <= u[15] ? {1'b0, u[14:12]} : 4'd8 - {1'b0, u[14:12]};
         end
         OP_EXP_ADD:  acc_ff  <= acc_ff + 64'(term_ff);
         OP_QM_CLEAR: pacc_ff <= '0;
         OP_QM_PROD:  prod_ff <= 64'(a_sel) * 64'(b_sel);
         OP_QM_ACC:   pacc_ff <= pacc_ff + pacc_add;
         OP_QM_DONE: begin
            acc_ff <= pacc_ff[113:50];
            mag_ff <= mag_ff - 4'd1;
         end
         OP_STORE:    mem[count_ff[AddrWidth-1:0]] <= acc_ff[61:34];
         OP_RD:       rd_ff <= mem[idx_ff];
         OP_ODIV_LOAD: begin
            drem_ff <= {7'd0, rd_ff};
            q_ff    <= '0;
         end
         OP_ODIV_STEP: begin
            drem_ff <= drem_in;
            q_ff    <= {q_ff[15:0], qbit};
         end
         OP_OUT_LOAD: begin
            out_ff.probability <= (sum_ff == '0 || q_ff[16]) ? 16'hFFFF : q_ff[15:0];
            out_ff.position    <= 6'(idx_ff);
            out_ff.final_res   <= idx_final;
            out_ff.overflowed  <= drop_ff;
         end
         default: begin
         end
      endcase
   end

   // control state: fill count, sum, drop flag, read pointer, last marker
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         idx_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         unique case (cmd.op)
            OP_EXP_LOAD: last_ff <= req_data.last;
            OP_DROP: begin
               last_ff <= req_data.last;
               drop_ff <= 1'b1;
            end
            OP_STORE: begin
               sum_ff   <= sum_ff + {6'd0, acc_ff[61:34]};
               count_ff <= count_ff + CntWidth'(1);
            end
            OP_OUT_NEXT: idx_ff <= idx_ff + AddrWidth'(1);
            OP_CLEAR: begin
               sum_ff   <= '0;
               count_ff <= '0;
               drop_ff  <= 1'b0;
               idx_ff   <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   assign status.full      = count_ff == CntWidth'(MAX_LEN);
   assign status.mag_zero  = mag_ff == 4'd0;
   assign status.last      = last_ff;
   assign status.idx_final = idx_final;
   assign rsp_data         = out_ff;

endmodule

// File: rtl/core/smx_ctrl.sv
module smx_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  smx_pkg::dp_status_type status,
   output smx_pkg::dp_cmd_type   cmd
);
   import smx_pkg::*;

   smx_state_type state_ff, state_in;
   logic [4:0] k_ff, k_in;
   logic [4:0] cyc_ff, cyc_in;
   logic [1:0] pp_ff, pp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT_START;
         k_ff     <= 5'd1;
         cyc_ff   <= '0;
         pp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         cyc_ff   <= cyc_in;
         pp_ff    <= pp_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      k_in      = k_ff;
      cyc_in    = cyc_ff;
      pp_in     = pp_ff;
      cmd.op    = OP_NONE;
      cmd.k     = k_ff;
      cmd.pp    = pp_ff;
      cmd.first = cyc_ff == '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_INIT_START: begin
            cmd.op   = OP_INIT_LOAD;
            k_in     = 5'd1;
            state_in = S_INIT_MUL;
         end
         S_INIT_MUL, S_EXP_MUL: begin
            cmd.op   = OP_SER_MUL;
            cyc_in   = '0;
            state_in = (state_ff == S_INIT_MUL) ? S_INIT_DIV : S_EXP_DIV;
         end
         S_INIT_DIV, S_EXP_DIV: begin
            cmd.op = OP_SER_DIV;
            cyc_in = cyc_ff + 5'd1;
            if (cyc_ff == 5'(TERM_DIV_STEPS - 1)) begin
               state_in = (state_ff == S_INIT_DIV) ? S_INIT_ADD : S_EXP_ADD;
            end
         end
         S_INIT_ADD: begin
            cmd.op = OP_INIT_ADD;
            k_in   = k_ff + 5'd1;
            state_in = (k_ff == 5'(SERIES_TERMS)) ? S_IDLE : S_INIT_MUL;
         end
         S_IDLE: begin
            req_stall = 1'b0;
            k_in      = 5'd1;
            if (req_valid) begin
               if (status.full) begin
                  cmd.op   = OP_DROP;
                  // a dropped beat skips the exponential entirely
                  state_in = S_STORE;
               end else begin
                  cmd.op   = OP_EXP_LOAD;
                  state_in = S_EXP_MUL;
               end
            end
         end
         S_EXP_ADD: begin
            cmd.op = OP_EXP_ADD;
            k_in   = k_ff + 5'd1;
            state_in = (k_ff == 5'(SERIES_TERMS)) ? S_QM_START : S_EXP_MUL;
         end
         S_QM_START: begin
            pp_in = '0;
            if (status.mag_zero) begin
               state_in = S_STORE;
            end else begin
               cmd.op   = OP_QM_CLEAR;
               state_in = S_QM_PROD;
            end
         end
         S_QM_PROD: begin
            cmd.op   = OP_QM_PROD;
            state_in = S_QM_ACC;
         end
         S_QM_ACC: begin
            cmd.op   = OP_QM_ACC;
            pp_in    = pp_ff + 2'd1;
            state_in = (pp_ff == 2'd3) ? S_QM_DONE : S_QM_PROD;
         end
         S_QM_DONE: begin
            cmd.op   = OP_QM_DONE;
            state_in = S_QM_START;
         end
         S_STORE: begin
            // store only if this beat was not dropped
            if (!status.full) begin
               cmd.op = OP_STORE;
            end
            state_in = status.last ? S_RD : S_IDLE;
         end
         S_RD: begin
            cmd.op   = OP_RD;
            state_in = S_ODIV_LOAD;
         end
         S_ODIV_LOAD: begin
            cmd.op   = OP_ODIV_LOAD;
            cyc_in   = '0;
            state_in = S_ODIV;
         end
         S_ODIV: begin
            cmd.op = OP_ODIV_STEP;
            cyc_in = cyc_ff + 5'd1;
            if (cyc_ff == 5'(OUT_DIV_STEPS - 1)) begin
               state_in = S_OUT_LOAD;
            end
         end
         S_OUT_LOAD: begin
            cmd.op   = OP_OUT_LOAD;
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (status.idx_final) begin
                  cmd.op   = OP_CLEAR;
                  state_in = S_IDLE;
               end else begin
                  cmd.op   = OP_OUT_NEXT;
                  state_in = S_RD;
               end
            end
         end
         default: state_in = S_INIT_START;
      endcase
   end

endmodule
